FILE: hdl/deq_pkg.sv
// Package for the double-ended queue: operation and status codes and the
// control structs passed from the top level to the storage chains.
// Depends on nothing.
package deq_pkg;

    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_POP_BACK   = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_CLEAR      = 3'd4
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef struct packed {
        logic push_head;
        logic pop_head;
        logic write_tail;
    } t_chain_ctrl;

    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic load;
    } t_cell_ctrl;

endpackage

FILE: hdl/double_ended_queue.sv
// Bounded double-ended queue of 32-bit signed words held in two cell chains.
// The result is registered and shown in the cycle after the request is accepted.
// Throughput: one request per cycle; a push shifts one chain and writes the
// other's tail, a pop shifts one chain; a request waits only on a held result.
// Reset: synchronous active-low; count and result valid clear, cells keep data.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [deq_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [deq_pkg::DATA_W-1:0]   i_data_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [deq_pkg::DATA_W-1:0]   o_data_out,
    output logic [deq_pkg::STATUS_W-1:0]        o_status,
    output logic [deq_pkg::COUNT_W-1:0]         o_count,
    output logic                                o_is_empty
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Chain A holds the queue front first, chain B holds it back first.
    logic                      w_accept;
    logic                      w_full;
    logic                      w_empty;
    logic [DATA_W-1:0]         w_head_a;
    logic [DATA_W-1:0]         w_head_b;
    t_chain_ctrl               w_op_a;
    t_chain_ctrl               w_op_b;
    t_chain_ctrl               w_ctrl_a;
    t_chain_ctrl               w_ctrl_b;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_out_valid;
    logic [DATA_W-1:0]         r_data;
    logic [DATA_W-1:0]         n_data;
    t_status                   r_status;
    t_status                   n_status;
    logic [CNT_W+COUNT_W-1:0]  w_count_ext;

    assign o_in_ready = i_rst_n && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);

    always_comb begin
        w_op_a   = '0;
        w_op_b   = '0;
        n_count  = r_count;
        n_data   = '0;
        n_status = ST_OK;
        case (t_mode'(i_mode))
            MODE_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    w_op_b.push_head  = 1'b1;
                    w_op_a.write_tail = 1'b1;
                    n_count           = r_count + 1'b1;
                end
            end
            MODE_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    w_op_a.push_head  = 1'b1;
                    w_op_b.write_tail = 1'b1;
                    n_count           = r_count + 1'b1;
                end
            end
            MODE_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    w_op_b.pop_head = 1'b1;
                    n_data          = w_head_b;
                    n_count         = r_count - 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    w_op_a.pop_head = 1'b1;
                    n_data          = w_head_a;
                    n_count         = r_count - 1'b1;
                end
            end
            MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign w_ctrl_a = w_accept ? w_op_a : '0;
    assign w_ctrl_b = w_accept ? w_op_b : '0;

    deq_chain #(
        .DEPTH (DEPTH)
    ) u_chain_a (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl_a),
        .i_data  (i_data_in),
        .i_count (r_count),
        .o_head  (w_head_a)
    );

    deq_chain #(
        .DEPTH (DEPTH)
    ) u_chain_b (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl_b),
        .i_data  (i_data_in),
        .i_count (r_count),
        .o_head  (w_head_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data   <= n_data;
            r_status <= n_status;
        end
    end

    assign w_count_ext = {{COUNT_W{1'b0}}, r_count};

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data;
    assign o_status    = r_status;
    assign o_count     = w_count_ext[COUNT_W-1:0];
    assign o_is_empty  = (r_count == '0);

endmodule

FILE: hdl/deq_cell.sv
// One storage cell of a deque chain: holds one word and takes it from the
// lower neighbor, the upper neighbor or the tail write port.
// Depends on deq_pkg.
module deq_cell (
    input  logic                       i_clk,
    input  deq_pkg::t_cell_ctrl        i_ctrl,
    input  logic [deq_pkg::DATA_W-1:0] i_from_lower,
    input  logic [deq_pkg::DATA_W-1:0] i_from_upper,
    input  logic [deq_pkg::DATA_W-1:0] i_load_data,
    output logic [deq_pkg::DATA_W-1:0] o_data
);
    import deq_pkg::*;

    logic [DATA_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_up) begin
            r_data <= i_from_lower;
        end else if (i_ctrl.shift_down) begin
            r_data <= i_from_upper;
        end else if (i_ctrl.load) begin
            r_data <= i_load_data;
        end
    end

    assign o_data = r_data;

endmodule

FILE: hdl/deq_chain.sv
// A row of deque cells ordered from one end of the queue: cell zero holds
// the end element, and the element count selects the tail write slot.
// Depends on deq_pkg and deq_cell.
module deq_chain #(
    parameter int DEPTH = 16
) (
    input  logic                           i_clk,
    input  deq_pkg::t_chain_ctrl           i_ctrl,
    input  logic [deq_pkg::DATA_W-1:0]     i_data,
    input  logic [$clog2(DEPTH+1)-1:0]     i_count,
    output logic [deq_pkg::DATA_W-1:0]     o_head
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] w_data [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_ctrl        w_ctrl;
        logic [DATA_W-1:0] w_lower;
        logic [DATA_W-1:0] w_upper;

        assign w_ctrl.shift_up   = i_ctrl.push_head;
        assign w_ctrl.shift_down = i_ctrl.pop_head;
        assign w_ctrl.load       = i_ctrl.write_tail && (i_count == CNT_W'(g));

        if (g == 0) begin : g_first
            assign w_lower = i_data;
        end else begin : g_mid_lower
            assign w_lower = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_upper = '0;
        end else begin : g_mid_upper
            assign w_upper = w_data[g+1];
        end

        deq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_from_lower (w_lower),
            .i_from_upper (w_upper),
            .i_load_data  (i_data),
            .o_data       (w_data[g])
        );
    end

    assign o_head = w_data[0];

endmodule

FILE: hdl/deq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on deq_pkg and double_ended_queue.
module deq_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic [deq_pkg::MODE_W-1:0]          i_mode,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [deq_pkg::DATA_W-1:0]   o_data_out,
    input logic [deq_pkg::STATUS_W-1:0]        o_status,
    input logic [deq_pkg::COUNT_W-1:0]         o_count,
    input logic                                o_is_empty
);
    import deq_pkg::*;

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_data_out)
            && $stable(o_status) && $stable(o_count) && $stable(o_is_empty))
        else $error("Result changed while stalled.");

    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("Request taken while a result was stalled.");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_empty |-> o_count == '0)
        else $error("Empty flag set with a nonzero count.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_data_out == '0)
        else $error("Failed operation returned data.");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_mode == MODE_CLEAR) |=>
            o_out_valid && o_is_empty && (o_status == ST_OK) && (o_data_out == '0))
        else $error("Clear did not empty the queue.");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench for the double-ended queue: random and directed
// requests, a per-request model of the ring, and field-by-field result checks.
// Depends on deq_pkg and double_ended_queue.
`timescale 1ns / 1ps

module testbench;
    import deq_pkg::*;

    localparam int RING_DEPTH = 16;
    localparam int RANDOM_REQS = 1650;
    localparam int IDLE_LIMIT = 1000;
    localparam int TAIL_CYCLES = 4;
    localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_LAST = 3'd7;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic signed [DATA_W-1:0] data;
        bit hold_off;
    } t_op;

    typedef struct {
        logic signed [DATA_W-1:0] data_out;
        t_status status;
        logic [COUNT_W-1:0] count;
        logic is_empty;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [MODE_W-1:0] i_mode = '0;
    logic signed [DATA_W-1:0] i_data_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [DATA_W-1:0] o_data_out;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0] o_count;
    logic o_is_empty;

    double_ended_queue #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_mode(i_mode),
        .i_data_in(i_data_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_data_out(o_data_out),
        .o_status(o_status),
        .o_count(o_count),
        .o_is_empty(o_is_empty)
    );

    t_op op_queue[$];
    t_result awaited_results[$];
    logic signed [DATA_W-1:0] shadow_ring[RING_DEPTH];
    int head_idx = 0;
    int tail_idx = 0;
    int fill_level = 0;
    int total_reqs = 0;
    int counted_reqs = 0;
    int issued_cnt = 0;
    int accepted_cnt = 0;
    int idle_cycles = 0;
    int err_count = 0;
    logic in_taken = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int ring_next(int idx);
        return (idx == RING_DEPTH - 1) ? 0 : idx + 1;
    endfunction

    function automatic int ring_prev(int idx);
        return (idx == 0) ? RING_DEPTH - 1 : idx - 1;
    endfunction

    function automatic t_result apply_deque_op(logic [MODE_W-1:0] mode,
                                               logic signed [DATA_W-1:0] data);
        t_result res;
        res.data_out = '0;
        res.status = ST_OK;
        case (mode)
            MODE_PUSH_BACK: begin
                if (fill_level >= RING_DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    shadow_ring[tail_idx] = data;
                    tail_idx = ring_next(tail_idx);
                    fill_level++;
                end
            end
            MODE_PUSH_FRONT: begin
                if (fill_level >= RING_DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    head_idx = ring_prev(head_idx);
                    shadow_ring[head_idx] = data;
                    fill_level++;
                end
            end
            MODE_POP_BACK: begin
                if (fill_level == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    tail_idx = ring_prev(tail_idx);
                    res.data_out = shadow_ring[tail_idx];
                    fill_level--;
                end
            end
            MODE_POP_FRONT: begin
                if (fill_level == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    res.data_out = shadow_ring[head_idx];
                    head_idx = ring_next(head_idx);
                    fill_level--;
                end
            end
            MODE_CLEAR: begin
                head_idx = 0;
                tail_idx = 0;
                fill_level = 0;
            end
            default: begin
            end
        endcase
        res.count = fill_level[COUNT_W-1:0];
        res.is_empty = (fill_level == 0);
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_word();
        case ($urandom_range(15))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(logic [MODE_W-1:0] mode, logic signed [DATA_W-1:0] data);
        t_op op;
        op.mode = mode;
        op.data = data;
        op.hold_off = 1'b0;
        op_queue.push_back(op);
        if (mode <= MODE_CLEAR) begin
            counted_reqs++;
        end
    endtask

    function automatic logic [MODE_W-1:0] rand_push();
        return $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
    endfunction

    function automatic logic [MODE_W-1:0] rand_pop();
        return $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK;
    endfunction

    // Sender and receiver idle rates follow the progress through the request list.
    function automatic int send_idle_pct();
        if (issued_cnt < total_reqs / 3) begin
            return 38;
        end else if (issued_cnt < 2 * total_reqs / 3) begin
            return 73;
        end
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (issued_cnt < total_reqs / 3) begin
            return 73;
        end else if (issued_cnt < 2 * total_reqs / 3) begin
            return 38;
        end
        return 0;
    endfunction

    always @(negedge i_clk) begin : drive
        logic next_valid;
        t_op op;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct());
            next_valid = i_in_valid && !in_taken;
            if (!next_valid && op_queue.size() != 0) begin
                if (!(op_queue[0].hold_off && awaited_results.size() != 0) &&
                        $urandom_range(99) >= send_idle_pct()) begin
                    op = op_queue.pop_front();
                    i_mode <= op.mode;
                    i_data_in <= op.data;
                    next_valid = 1'b1;
                    issued_cnt++;
                end
            end
            i_in_valid <= next_valid;
        end
    end

    always @(posedge i_clk) begin : observe
        t_result exp_r;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no request outstanding: data_out %0d", o_data_out);
                    err_count++;
                end else begin
                    exp_r = awaited_results.pop_front();
                    if (o_data_out !== exp_r.data_out) begin
                        $error("data_out: expected %0d, got %0d", exp_r.data_out, o_data_out);
                        err_count++;
                    end
                    if (o_status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, o_status);
                        err_count++;
                    end
                    if (o_count !== exp_r.count) begin
                        $error("count: expected %0d, got %0d", exp_r.count, o_count);
                        err_count++;
                    end
                    if (o_is_empty !== exp_r.is_empty) begin
                        $error("is_empty: expected %0d, got %0d", exp_r.is_empty, o_is_empty);
                        err_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                awaited_results.push_back(apply_deque_op(i_mode, i_data_in));
                accepted_cnt <= accepted_cnt + 1;
            end
            in_taken <= i_in_valid && o_in_ready;
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : run
        int directed_n;
        int seg_len;
        int sel;
        add_op(MODE_POP_BACK, rand_word());
        add_op(MODE_POP_FRONT, rand_word());
        for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++) begin
            add_op(m[MODE_W-1:0], rand_word());
        end
        add_op(MODE_PUSH_BACK, WORD_MAX);
        add_op(MODE_PUSH_FRONT, WORD_MIN);
        add_op(MODE_PUSH_BACK, '1);
        add_op(MODE_PUSH_FRONT, '0);
        add_op(MODE_PUSH_BACK, 32'sd1);
        add_op(MODE_POP_FRONT, WORD_MAX);
        add_op(MODE_POP_BACK, WORD_MIN);
        add_op(MODE_POP_FRONT, '0);
        add_op(MODE_POP_BACK, '1);
        add_op(MODE_CLEAR, WORD_MAX);
        add_op(MODE_POP_BACK, '0);
        add_op(MODE_PUSH_FRONT, 32'sh5A5A_5A5A);
        add_op(MODE_POP_BACK, 32'shA5A5_A5A5);
        directed_n = op_queue.size();
        counted_reqs = 0;

        // Mostly runs that fill the ring past full or empty it past zero,
        // with mixed stretches, clears and unused modes in between.
        while (counted_reqs < RANDOM_REQS) begin
            sel = $urandom_range(99);
            if (sel < 30) begin
                seg_len = $urandom_range(RING_DEPTH, RING_DEPTH + 4);
                repeat (seg_len) add_op(rand_push(), rand_word());
            end else if (sel < 60) begin
                seg_len = $urandom_range(RING_DEPTH, RING_DEPTH + 4);
                repeat (seg_len) add_op(rand_pop(), rand_word());
            end else if (sel < 95) begin
                seg_len = $urandom_range(8, 24);
                repeat (seg_len) begin
                    sel = $urandom_range(99);
                    if (sel < 46) begin
                        add_op(rand_push(), rand_word());
                    end else if (sel < 92) begin
                        add_op(rand_pop(), rand_word());
                    end else if (sel < 96) begin
                        add_op(MODE_CLEAR, rand_word());
                    end else begin
                        add_op(MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST)),
                               rand_word());
                    end
                end
            end else begin
                add_op(MODE_CLEAR, rand_word());
            end
        end
        total_reqs = op_queue.size();
        op_queue[directed_n].hold_off = 1'b1;
        op_queue[total_reqs / 3].hold_off = 1'b1;
        op_queue[2 * total_reqs / 3].hold_off = 1'b1;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(accepted_cnt == total_reqs && awaited_results.size() == 0) &&
                idle_cycles < IDLE_LIMIT) begin
            @(negedge i_clk);
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: FAIL");
        end else begin
            repeat (TAIL_CYCLES) @(negedge i_clk);
            if (err_count == 0) begin
                $display("testbench: PASS");
            end else begin
                $display("testbench: FAIL");
            end
        end
        $finish;
    end

endmodule
